// ===== rtl/fp8_scaled_dot_product_core_macros.svh =====
// Assertion macros used by the RTL controller.
`ifndef FP8_SCALED_DOT_PRODUCT_CORE_MACROS_SVH
`define FP8_SCALED_DOT_PRODUCT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FP8SDP_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FP8SDP_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FP8SDP_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define FP8SDP_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/fp8sdp_pkg.sv =====
package fp8sdp_pkg;

	localparam int MAX_ELEMENTS_DEF = 65536;
	localparam int ACC_W = 54;
	localparam int MAN_W = 53;
	localparam int SC_W = 24;
	localparam int PROD_W = MAN_W + SC_W;
	localparam int EXP_W = 13;
	localparam int STAT_W = 3;

	localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_ACT = 3'd1;
	localparam logic [STAT_W-1:0] STAT_BAD_WGT = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NAN     = 3'd3;
	localparam logic [STAT_W-1:0] STAT_OVF     = 3'd4;

	localparam logic CFG_ACT = 1'b0;
	localparam logic CFG_WGT = 1'b1;

	typedef struct packed {
		logic acc_en;
		logic chk;
		logic norm;
		logic sld;
		logic snorm;
		logic mlo;
		logic mhi;
		logic rnd;
		logic phase;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic man_msb;
		logic sc_msb;
		logic out_busy;
	} sts_t;

	function automatic logic float_good(input logic [31:0] b);
		return !b[31] && (b[30:23] != 8'hFF) && (b != 32'd0);
	endfunction

endpackage

// ===== rtl/fp8sdp_dp.sv =====
module fp8sdp_dp
	import fp8sdp_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic [15:0]  s_axis_tdata,   // activation_code, weight_code
	input  logic         cfg_valid,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [71:0]  m_axis_tdata    // result_bits, status
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 2);

	logic [31:0]          act_scale_q;
	logic [15:0]          wgt_scale_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 bad_q;
	logic [MAN_W-1:0]     man_q;
	logic signed [EXP_W-1:0] exp_q;
	logic                 neg_q;
	logic                 zero_q;
	logic [STAT_W-1:0]    stat_q;
	logic [SC_W-1:0]      sc_q;
	logic signed [EXP_W-1:0] esc_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 out_valid_q;
	logic [71:0]          out_data_q;

	// element product
	logic [7:0]  a_code, w_code;
	logic [3:0]  ma4, mw4;
	logic [3:0]  sha, shw;
	logic [7:0]  p8;
	logic [ACC_W-1:0] pmag;
	logic        elem_nan;

	assign a_code = s_axis_tdata[7:0];
	assign w_code = s_axis_tdata[15:8];
	assign elem_nan = (&a_code[6:0]) || (&w_code[6:0]);
	assign ma4 = {|a_code[6:3], a_code[2:0]};
	assign mw4 = {|w_code[6:3], w_code[2:0]};
	assign sha = (a_code[6:3] == 4'd0) ? 4'd0 : a_code[6:3] - 4'd1;
	assign shw = (w_code[6:3] == 4'd0) ? 4'd0 : w_code[6:3] - 4'd1;
	assign p8 = ma4 * mw4;
	assign pmag = ACC_W'(p8) << ({1'b0, sha} + {1'b0, shw});

	// vector close
	logic [STAT_W-1:0] stat_c;
	logic [ACC_W-1:0]  acc_abs;

	always_comb begin
		if (cnt_q > CNT_W'(MAX_ELEMENTS))
			stat_c = STAT_OVF;
		else if (!float_good(act_scale_q))
			stat_c = STAT_BAD_ACT;
		else if (!float_good({wgt_scale_q, 16'd0}))
			stat_c = STAT_BAD_WGT;
		else if (bad_q)
			stat_c = STAT_NAN;
		else
			stat_c = STAT_OK;
	end

	assign acc_abs = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);

	// scale decode
	logic [SC_W-1:0]         sc_ld;
	logic signed [EXP_W-1:0] esc_ld;

	always_comb begin
		if (!cmd.phase) begin
			sc_ld = {|act_scale_q[30:23], act_scale_q[22:0]};
			esc_ld = (act_scale_q[30:23] == 8'd0) ? -EXP_W'(149)
				: EXP_W'({5'd0, act_scale_q[30:23]}) - EXP_W'(150);
		end else begin
			sc_ld = {|wgt_scale_q[14:7], wgt_scale_q[6:0], 16'd0};
			esc_ld = (wgt_scale_q[14:7] == 8'd0) ? -EXP_W'(149)
				: EXP_W'({5'd0, wgt_scale_q[14:7]}) - EXP_W'(150);
		end
	end

	// round to nearest even
	logic [MAN_W-1:0]  keep;
	logic              guard, sticky, inc;
	logic [MAN_W:0]    rsum;

	always_comb begin
		if (prod_q[PROD_W-1]) begin
			keep = prod_q[PROD_W-1 -: MAN_W];
			guard = prod_q[SC_W-1];
			sticky = |prod_q[SC_W-2:0];
		end else begin
			keep = prod_q[PROD_W-2 -: MAN_W];
			guard = prod_q[SC_W-2];
			sticky = |prod_q[SC_W-3:0];
		end
		inc = guard && (sticky || keep[0]);
		rsum = {1'b0, keep} + (MAN_W+1)'(inc);
	end

	logic [10:0] ebias;
	assign ebias = 11'(exp_q + EXP_W'(52 + 1023));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_scale_q <= 32'h3F80_0000;
			wgt_scale_q <= 16'h3F80;
			acc_q <= '0;
			cnt_q <= '0;
			bad_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_ACT: act_scale_q <= cfg_data;
					CFG_WGT: wgt_scale_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (cmd.acc_en) begin
				if (cnt_q >= CNT_W'(MAX_ELEMENTS)) begin
					cnt_q <= CNT_W'(MAX_ELEMENTS + 1);
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (elem_nan)
						bad_q <= 1'b1;
					else if (a_code[7] ^ w_code[7])
						acc_q <= acc_q - $signed(pmag);
					else
						acc_q <= acc_q + $signed(pmag);
				end
			end
			if (cmd.chk) begin
				acc_q <= '0;
				cnt_q <= '0;
				bad_q <= 1'b0;
			end
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chk) begin
			man_q <= acc_abs[MAN_W-1:0];
			neg_q <= acc_q[ACC_W-1];
			exp_q <= -EXP_W'(18);
			stat_q <= stat_c;
			zero_q <= (stat_c != STAT_OK) || (acc_q == '0);
		end
		if (cmd.norm) begin
			man_q <= {man_q[MAN_W-2:0], 1'b0};
			exp_q <= exp_q - EXP_W'(1);
		end
		if (cmd.sld) begin
			sc_q <= sc_ld;
			esc_q <= esc_ld;
		end
		if (cmd.snorm) begin
			sc_q <= {sc_q[SC_W-2:0], 1'b0};
			esc_q <= esc_q - EXP_W'(1);
		end
		if (cmd.mlo)
			prod_q <= PROD_W'({12'd0, man_q} * sc_q[11:0]);
		if (cmd.mhi)
			prod_q <= prod_q + (PROD_W'({12'd0, man_q} * sc_q[23:12]) << 12);
		if (cmd.rnd) begin
			man_q <= rsum[MAN_W] ? rsum[MAN_W:1] : rsum[MAN_W-1:0];
			exp_q <= exp_q + esc_q + (prod_q[PROD_W-1] ? EXP_W'(24) : EXP_W'(23))
				+ EXP_W'(rsum[MAN_W]);
		end
		if (cmd.out_load) begin
			out_data_q[71:67] <= '0;
			out_data_q[66:64] <= stat_q;
			out_data_q[63:0] <= zero_q ? 64'd0 : {neg_q, ebias, man_q[51:0]};
		end
	end

	assign sts.skip = (stat_c != STAT_OK) || (acc_q == '0);
	assign sts.man_msb = man_q[MAN_W-1];
	assign sts.sc_msb = sc_q[SC_W-1];
	assign sts.out_busy = out_valid_q && !m_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule

// ===== rtl/fp8sdp_ctrl.sv =====
`include "fp8_scaled_dot_product_core_macros.svh"

module fp8sdp_ctrl
	import fp8sdp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic s_axis_tlast,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_NORM  = 4'd2;
	localparam logic [3:0] S_SLD   = 4'd3;
	localparam logic [3:0] S_SNORM = 4'd4;
	localparam logic [3:0] S_MLO   = 4'd5;
	localparam logic [3:0] S_MHI   = 4'd6;
	localparam logic [3:0] S_RND   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q, state_d;
	logic       phase_q, phase_d;

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd = '0;
		cmd.phase = phase_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.acc_en = s_axis_tvalid;
				if (s_axis_tvalid && s_axis_tlast)
					state_d = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				phase_d = 1'b0;
				state_d = sts.skip ? S_OUT : S_NORM;
			end
			S_NORM: begin
				if (sts.man_msb)
					state_d = S_SLD;
				else
					cmd.norm = 1'b1;
			end
			S_SLD: begin
				cmd.sld = 1'b1;
				state_d = S_SNORM;
			end
			S_SNORM: begin
				if (sts.sc_msb)
					state_d = S_MLO;
				else
					cmd.snorm = 1'b1;
			end
			S_MLO: begin
				cmd.mlo = 1'b1;
				state_d = S_MHI;
			end
			S_MHI: begin
				cmd.mhi = 1'b1;
				state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd = 1'b1;
				// second pass applies the weight scale
				if (!phase_q) begin
					phase_d = 1'b1;
					state_d = S_SLD;
				end else begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);

	`FP8SDP_ASSERT_NXT(a_last_closes, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tlast, state_q == S_CHK)
	`FP8SDP_ASSERT_NXT(a_mul_then_round, clk, arst_n, state_q == S_MHI, state_q == S_RND)
	`FP8SDP_ASSERT_IMP(a_out_only_free, clk, arst_n, cmd.out_load, !sts.out_busy && state_q == S_OUT)

endmodule

// ===== rtl/fp8_scaled_dot_product_core.sv =====
// Scaled FP8 E4M3FN dot product.
// Slave stream: one beat per element pair, tdata = {weight, activation} codes,
// tlast closes the vector. Master stream: one beat per vector, tdata holds the
// IEEE double result in bits 63:0 and the status in bits 66:64.
// Config channel: index 0 is the float32 activation scale, index 1 the bf16
// weight scale (cfg_data[15:0]); writes are always taken.
// Non-last beats are taken one per cycle. A last beat is followed by a close
// sequence: a check step, normalising the sum, then per scale a load step,
// normalising the scale, a low-half and a high-half multiply step and a
// rounding step, then an output step; the normalising shifts move one bit a
// cycle. Errors and a zero sum skip straight from the check to the output step.
// The output register holds a result while the receiver stalls; the close
// sequence waits in its output step until that register is free.
// Reset clears the sum, the count and the NaN mark, and sets both scales to 1.0.
module fp8_scaled_dot_product_core
	import fp8sdp_pkg::*;
#(
	parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // activation_code, weight_code
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,   // result_bits, status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fp8sdp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tlast  (s_axis_tlast),
		.sts           (sts),
		.cmd           (cmd)
	);

	fp8sdp_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import fp8sdp_pkg::*;

	typedef struct {
		logic [63:0] bits;
		logic [2:0]  st;
	} dot_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [31:0] cfg_data;

	dot_result_t pending_results[$];
	int          error_count = 0;
	int          tx_gap_max = 16;
	int          rx_gap_max = 16;
	bit          rx_hold_req = 0;

	// predictor state
	logic [31:0] act_scale = 32'h3F80_0000;
	logic [15:0] wgt_scale = 16'h3F80;
	longint      dot_sum = 0;
	int          pair_count = 0;
	bit          nan_seen = 0;

	fp8_scaled_dot_product_core u_top (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic real pow2(input int n);
		real r;
		r = 1.0;
		if (n >= 0)
			repeat (n) r = r * 2.0;
		else
			repeat (-n) r = r * 0.5;
		return r;
	endfunction

	function automatic real f32_value(input logic [31:0] b);
		if (b[30:23] == 8'd0)
			return real'(b[22:0]) * pow2(-149);
		return real'({1'b1, b[22:0]}) * pow2(int'(b[30:23]) - 150);
	endfunction

	function automatic bit scale_ok(input logic [31:0] b);
		return !b[31] && b[30:23] != 8'hFF && b != 32'd0;
	endfunction

	function automatic longint fp8_mag(input logic [7:0] c);
		if (c[6:3] == 4'd0)
			return longint'(c[2:0]);
		return longint'({1'b1, c[2:0]}) <<< (c[6:3] - 1);
	endfunction

	// Fold one accepted pair into the predicted sum; queue a result on last.
	task automatic predict_pair(input logic [7:0] a, input logic [7:0] w, input logic lst);
		dot_result_t r;
		real v;
		longint p;
		if (pair_count >= MAX_ELEMENTS_DEF) begin
			pair_count = MAX_ELEMENTS_DEF + 1;
		end else begin
			pair_count++;
			if (a[6:0] == 7'h7F || w[6:0] == 7'h7F) begin
				nan_seen = 1;
			end else begin
				p = fp8_mag(a) * fp8_mag(w);
				dot_sum = (a[7] ^ w[7]) ? dot_sum - p : dot_sum + p;
			end
		end
		if (!lst)
			return;
		r.bits = 64'd0;
		if (pair_count > MAX_ELEMENTS_DEF)
			r.st = STAT_OVF;
		else if (!scale_ok(act_scale))
			r.st = STAT_BAD_ACT;
		else if (!scale_ok({wgt_scale, 16'd0}))
			r.st = STAT_BAD_WGT;
		else if (nan_seen)
			r.st = STAT_NAN;
		else
			r.st = STAT_OK;
		if (r.st == STAT_OK) begin
			v = real'(dot_sum) * pow2(-18);
			v = v * f32_value(act_scale);
			v = v * f32_value({wgt_scale, 16'd0});
			r.bits = (v == 0.0) ? 64'd0 : $realtobits(v);
		end
		pending_results.insert(pending_results.size(), r);
		dot_sum = 0;
		pair_count = 0;
		nan_seen = 0;
	endtask

	task automatic send_pair(input logic [7:0] a, input logic [7:0] w, input logic lst);
		int gap;
		gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {w, a};
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		predict_pair(a, w, lst);
	endtask

	task automatic end_stream();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		end_stream();
		wait (pending_results.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_scale(input logic idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_ACT)
			act_scale = data;
		else
			wgt_scale = data[15:0];
	endtask

	task automatic set_scales(input logic [31:0] act, input logic [15:0] wgt);
		wait_drained();
		write_scale(CFG_ACT, act);
		write_scale(CFG_WGT, {16'($urandom), wgt});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] rand_code();
		logic [7:0] c;
		c = 8'($urandom);
		// keep NaN codes rare so most vectors come out clean
		if (c[6:0] == 7'h7F && $urandom_range(0, 3) != 0)
			c[0] = 1'b0;
		return c;
	endfunction

	task automatic send_vector(input int len);
		for (int i = 0; i < len; i++)
			send_pair(rand_code(), rand_code(), i == len - 1);
	endtask

	task automatic test_directed();
		send_pair(8'h00, 8'h00, 1'b1);              // zero sum
		send_pair(8'h7E, 8'h7E, 1'b1);              // largest finite
		send_pair(8'hFE, 8'h7E, 1'b1);              // negative product
		send_pair(8'h01, 8'h81, 1'b1);              // smallest subnormals
		send_pair(8'h38, 8'h40, 1'b0);
		send_pair(8'hB8, 8'h40, 1'b1);              // cancels to exact zero
		send_pair(8'h7F, 8'h38, 1'b1);              // NaN activation
		send_pair(8'h38, 8'hFF, 1'b0);              // NaN weight, mid vector
		send_pair(8'h38, 8'h38, 1'b1);
		send_pair(8'h80, 8'h00, 1'b1);              // signed zeros
		send_pair(8'hFE, 8'h7E, 1'b0);
		send_pair(8'hFE, 8'h7E, 1'b0);
		send_pair(8'hFE, 8'hFE, 1'b1);
		send_pair(8'h08, 8'h77, 1'b1);
	endtask

	task automatic test_scales();
		logic [31:0] acts[$] = '{32'h7F7F_FFFF, 32'h0000_0001, 32'h0000_0000, 32'h8000_0000,
			32'h7F80_0000, 32'h7FC0_0000, 32'hBF80_0000, 32'h007F_FFFF, 32'h3F80_0000};
		logic [15:0] wgts[$] = '{16'h7F7F, 16'h0001, 16'h0000, 16'h8000, 16'h7F80, 16'h7FC1,
			16'hC000, 16'h3F80};
		foreach (acts[i]) begin
			set_scales(acts[i], 16'h3F80);
			send_vector(3);
			send_pair(8'h7F, 8'h7F, 1'b1);
		end
		foreach (wgts[i]) begin
			set_scales(32'h3FC0_0000, wgts[i]);
			send_vector(3);
			send_pair(8'hFF, 8'h38, 1'b1);
		end
		set_scales(32'h7F7F_FFFF, 16'h7F7F);
		send_vector(4);
		set_scales(32'h0000_0001, 16'h0001);
		send_vector(4);
	endtask

	task automatic test_random();
		logic [31:0] act;
		logic [15:0] wgt;
		int sent;
		sent = 0;
		while (sent < 1300) begin
			act = {1'b0, 8'($urandom_range(100, 154)), 23'($urandom)};
			wgt = {1'b0, 8'($urandom_range(100, 154)), 7'($urandom)};
			if ($urandom_range(0, 5) == 0)
				act = $urandom;
			if ($urandom_range(0, 5) == 0)
				wgt = 16'($urandom);
			set_scales(act, wgt);
			// alternate idle and back-to-back stretches
			tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
			rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 16;
			repeat (8) begin
				int len;
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
				send_vector(len);
				sent += len;
			end
		end
		tx_gap_max = 16;
		rx_gap_max = 16;
	endtask

	task automatic test_backpressure();
		wait_drained();
		tx_gap_max = 0;
		rx_hold_req = 1;
		repeat (40) send_vector($urandom_range(1, 3));
		tx_gap_max = 16;
	endtask

	// result checker and receiver stalls
	initial begin
		int stall;
		int hold;
		stall = 0;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				dot_result_t r;
				if (pending_results.size() == 0) begin
					$error("unexpected result %h", m_axis_tdata);
					error_count++;
				end else begin
					r = pending_results.pop_front();
					if (m_axis_tdata[63:0] !== r.bits) begin
						$error("result_bits expected %h actual %h", r.bits, m_axis_tdata[63:0]);
						error_count++;
					end
					if (m_axis_tdata[66:64] !== r.st) begin
						$error("status expected %0d actual %0d", r.st, m_axis_tdata[66:64]);
						error_count++;
					end
				end
				stall = (rx_gap_max == 0) ? 0 : $urandom_range(0, rx_gap_max);
			end
			if (rx_hold_req) begin
				rx_hold_req = 0;
				hold = 400;
			end
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20_000_000;
		$display("fp8_scaled_dot_product_core verification failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_ACT;
		cfg_data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_scales();
		test_random();
		test_backpressure();
		end_stream();
		wait (pending_results.size() == 0);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("fp8_scaled_dot_product_core verification clean");
		else
			$display("fp8_scaled_dot_product_core verification failed");
		$finish;
	end

endmodule
